// File: design/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg
// shared constants, types and helpers of the disparity error statistics block
// ----------------------------------------------------------------------------
package des_pkg;

  // accumulator sizing
  localparam int COUNT_WIDTH = 24;
  localparam int ERROR_CLAMP = 4;
  localparam int NUM_BINS    = ERROR_CLAMP + 1;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int SSE_W       = 40;

  // payload widths
  localparam int DISP_W  = 8;
  localparam int COLOR_W = 8;
  localparam int VCNT_W  = 24;
  localparam int PCT_W   = 15;
  localparam int RMS_W   = 16;
  localparam int NUM_THR = 4;
  localparam int THR_W   = $clog2(NUM_THR);

  // shared divide / root unit
  localparam int FRAC_W  = 16;
  localparam int DIV_W   = SSE_W + FRAC_W;
  localparam int ROOT_W  = DIV_W / 2;
  localparam int REM_W   = (COUNT_WIDTH + 2 > ROOT_W + 4) ? COUNT_WIDTH + 2 : ROOT_W + 4;
  localparam int STEP_W  = $clog2(DIV_W + 1);
  localparam int PROD_W  = COUNT_WIDTH + PCT_W;

  localparam logic [PCT_W-1:0]   PCT_SCALE = PCT_W'(25600);
  localparam logic [RMS_W-1:0]   RMS_CAP   = RMS_W'(65280);
  localparam logic [DISP_W-1:0]  OCC_RESET = DISP_W'(255);
  localparam logic [VCNT_W-1:0]  VCNT_MAX  = '1;

  localparam logic [COLOR_W-1:0] COLOR_TAB [4] = '{8'd255, 8'd200, 8'd40, 8'd20};

  // result kind codes
  localparam logic KIND_PIX = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CUM,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MS_GO,
    ST_MS_WAIT,
    ST_RT_GO,
    ST_RT_WAIT,
    ST_SUMMARY
  } des_state_e;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } des_mode_e;

  typedef struct packed {
    logic [NUM_BINS-1:0][COUNT_WIDTH-1:0] hist;
    logic [COUNT_WIDTH-1:0]               count;
    logic [SSE_W-1:0]                     sse;
  } des_stats_t;

  typedef struct packed {
    logic                   start;
    des_mode_e              mode;
    logic [DIV_W-1:0]       operand;
    logic [COUNT_WIDTH-1:0] divisor;
  } des_iter_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] result;
  } des_iter_rsp_t;

  typedef struct packed {
    logic                       kind;
    logic [COLOR_W-1:0]         map_value;
    logic [VCNT_W-1:0]          valid_count;
    logic [NUM_THR-1:0][PCT_W-1:0] bad_pct;
    logic [RMS_W-1:0]           rms_error;
    logic                       empty_flag;
    logic                       last;
  } des_res_t;

  // error-map color of a clamped error bin
  function automatic logic [COLOR_W-1:0] color_of(input logic [BIN_W-1:0] bin);
    logic [COLOR_W-1:0] color;
    color = '0;
    for (int i = 0; i < 4; i++) begin
      if (int'(bin) == i && i < ERROR_CLAMP) begin
        color = COLOR_TAB[i];
      end
    end
    return color;
  endfunction

  // saturating increment of a counter
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

// File: design/des_pix_if.sv
// ----------------------------------------------------------------------------
// des_pix_if
// pixel input channel: estimated and true disparity with frame end marker
// ----------------------------------------------------------------------------
interface des_pix_if;
  import des_pkg::*;

  logic              valid;
  logic              ready;
  logic [DISP_W-1:0] est_disp;
  logic [DISP_W-1:0] true_disp;
  logic              frame_end;

  modport source (
    output valid, est_disp, true_disp, frame_end,
    input  ready
  );

  modport sink (
    input  valid, est_disp, true_disp, frame_end,
    output ready
  );
endinterface

// File: design/des_res_if.sv
// ----------------------------------------------------------------------------
// des_res_if
// result channel: per-pixel error-map beats and frame summary beats
// ----------------------------------------------------------------------------
interface des_res_if;
  import des_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [COLOR_W-1:0] map_value;
  logic [VCNT_W-1:0]  valid_count;
  logic [PCT_W-1:0]   bad_pct_0;
  logic [PCT_W-1:0]   bad_pct_1;
  logic [PCT_W-1:0]   bad_pct_2;
  logic [PCT_W-1:0]   bad_pct_3;
  logic [RMS_W-1:0]   rms_error;
  logic               empty_flag;
  logic               last;

  modport source (
    output valid, kind, map_value, valid_count, bad_pct_0, bad_pct_1, bad_pct_2,
           bad_pct_3, rms_error, empty_flag, last,
    input  ready
  );

  modport sink (
    input  valid, kind, map_value, valid_count, bad_pct_0, bad_pct_1, bad_pct_2,
           bad_pct_3, rms_error, empty_flag, last,
    output ready
  );
endinterface

// File: design/disparity_error_statistics.sv
// ----------------------------------------------------------------------------
// disparity_error_statistics
// stereo disparity error map, bad-pixel percentages and rms error per frame
// ----------------------------------------------------------------------------
// pixel beat: result sits in the output register in the cycle after accept;
//   one pixel per cycle while the result side keeps taking beats
// frame end beat: summary beat after the shared unit runs five 56-step divides
//   and one 28-step root; no pixel taken then
// reset: accumulators clear, occluded label returns to 255, output empty
// ----------------------------------------------------------------------------
module disparity_error_statistics (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [des_pkg::DISP_W-1:0] cfg_wdata_i,
  des_pix_if.sink                    pix_i,
  des_res_if.source                  res_o
);
  import des_pkg::*;

  des_state_e             state_q, state_d;
  logic [THR_W-1:0]       k_q, k_d;
  logic [COUNT_WIDTH-1:0] cum_q, cum_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [NUM_THR-1:0][PCT_W-1:0] pct_q, pct_d;
  logic [RMS_W-1:0]       rms_q, rms_d;
  logic                   out_valid_q, out_valid_d;
  des_res_t               out_q, out_d;

  logic                   pix_ready;
  logic                   pix_take;
  logic                   clr;
  logic [COLOR_W-1:0]     color;
  des_stats_t             stats;
  des_iter_req_t          req;
  des_iter_rsp_t          rsp;

  // combinational helpers for the summary
  logic [COUNT_WIDTH-1:0] n;
  logic [COUNT_WIDTH-1:0] hist_sel;
  logic [COUNT_WIDTH:0]   cum_sum;
  logic [31:0]            n_ext;
  logic [VCNT_W-1:0]      vcount;
  logic [ROOT_W-1:0]      root;

  // ---------------------------------------------------------------------------
  // accumulators and the shared divide / root unit
  // ---------------------------------------------------------------------------
  des_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_i       (pix_take),
    .clr_i       (clr),
    .est_i       (pix_i.est_disp),
    .true_i      (pix_i.true_disp),
    .color_o     (color),
    .stats_o     (stats)
  );

  des_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // ---------------------------------------------------------------------------
  // summary datapath pieces
  // ---------------------------------------------------------------------------
  always_comb begin
    n        = stats.count;
    hist_sel = '0;
    // bin k joins the cumulative count only while it exists
    for (int b = 0; b < NUM_BINS; b++) begin
      if (b == int'(k_q)) begin
        hist_sel = stats.hist[b];
      end
    end
    cum_sum = {1'b0, cum_q} + {1'b0, hist_sel};
    // valid_count saturates at its own width
    n_ext   = 32'(n);
    vcount  = (n_ext > 32'(VCNT_MAX)) ? VCNT_MAX : n_ext[VCNT_W-1:0];
    root    = rsp.result[ROOT_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // sequencer: pixel beats in idle, then the summary steps on frame end
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cum_d       = cum_q;
    prod_d      = prod_q;
    pct_d       = pct_q;
    rms_d       = rms_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    pix_ready   = 1'b0;
    clr         = 1'b0;
    req         = '0;
    req.mode    = MODE_DIV;
    req.divisor = n;

    unique case (state_q)
      ST_IDLE: begin
        // output register parts the two sides: take a pixel while the old beat drains
        pix_ready = !out_valid_q || res_o.ready;
        if (pix_ready && pix_i.valid) begin
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.kind      = KIND_PIX;
          out_d.map_value = color;
          out_d.last      = !pix_i.frame_end;
          if (pix_i.frame_end) begin
            state_d = ST_CUM;
          end
        end
      end

      ST_CUM: begin
        // empty frame skips all arithmetic
        if (n == '0) begin
          state_d = ST_SUMMARY;
        end else begin
          if (int'(k_q) <= ERROR_CLAMP) begin
            cum_d = (cum_sum > {1'b0, n}) ? n : cum_sum[COUNT_WIDTH-1:0];
          end
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        // pixels worse than threshold k, scaled to Q7.8 percent
        prod_d  = PROD_W'(n - cum_q) * PROD_W'(PCT_SCALE);
        state_d = ST_DIV_GO;
      end

      ST_DIV_GO: begin
        req.start   = 1'b1;
        req.mode    = MODE_DIV;
        req.operand = DIV_W'(prod_q);
        state_d     = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (rsp.done) begin
          pct_d[k_q] = rsp.result[PCT_W-1:0];
          if (k_q == THR_W'(NUM_THR - 1)) begin
            state_d = ST_MS_GO;
          end else begin
            k_d     = k_q + THR_W'(1);
            state_d = ST_CUM;
          end
        end
      end

      ST_MS_GO: begin
        // mean squared error with 16 fraction bits
        req.start   = 1'b1;
        req.mode    = MODE_DIV;
        req.operand = {stats.sse, FRAC_W'(0)};
        state_d     = ST_MS_WAIT;
      end

      ST_MS_WAIT: begin
        if (rsp.done) begin
          state_d = ST_RT_GO;
        end
      end

      ST_RT_GO: begin
        // root of the quotient still held in the unit gives Q8.8
        req.start   = 1'b1;
        req.mode    = MODE_SQRT;
        req.operand = rsp.result;
        state_d     = ST_RT_WAIT;
      end

      ST_RT_WAIT: begin
        if (rsp.done) begin
          rms_d   = (root > ROOT_W'(RMS_CAP)) ? RMS_CAP : root[RMS_W-1:0];
          state_d = ST_SUMMARY;
        end
      end

      ST_SUMMARY: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d      = 1'b1;
          out_d            = '0;
          out_d.kind       = KIND_SUM;
          out_d.last       = 1'b1;
          if (n == '0) begin
            out_d.empty_flag = 1'b1;
          end else begin
            out_d.valid_count = vcount;
            out_d.bad_pct     = pct_q;
            out_d.rms_error   = rms_q;
          end
          clr     = 1'b1;
          k_d     = '0;
          cum_d   = '0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign pix_take = pix_ready && pix_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      cum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      cum_q       <= cum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    pct_q  <= pct_d;
    rms_q  <= rms_d;
    out_q  <= out_d;
  end

  // ---------------------------------------------------------------------------
  // ports
  // ---------------------------------------------------------------------------
  assign pix_i.ready       = pix_ready;
  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_q.kind;
  assign res_o.map_value   = out_q.map_value;
  assign res_o.valid_count = out_q.valid_count;
  assign res_o.bad_pct_0   = out_q.bad_pct[0];
  assign res_o.bad_pct_1   = out_q.bad_pct[1];
  assign res_o.bad_pct_2   = out_q.bad_pct[2];
  assign res_o.bad_pct_3   = out_q.bad_pct[3];
  assign res_o.rms_error   = out_q.rms_error;
  assign res_o.empty_flag  = out_q.empty_flag;
  assign res_o.last        = out_q.last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the shared unit is never restarted in the middle of an operation
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !rsp.busy)
    else $error("shared unit started while busy");

  // a frame end beat always launches the summary sequence
  a_frame_end_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_take && pix_i.frame_end) |=> (state_q == ST_CUM))
    else $error("frame end did not start summary");

  // emitting a summary leaves the accumulators empty
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (stats.count == '0) && (stats.sse == '0))
    else $error("accumulators not cleared after summary");

  // the cumulative bin count never passes the pixel count
  a_cum_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (cum_q <= stats.count))
    else $error("cumulative count above pixel count");

endmodule

// File: design/des_accum.sv
// ----------------------------------------------------------------------------
// des_accum
// per-pixel error classification and saturating frame accumulators
// ----------------------------------------------------------------------------
module des_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [des_pkg::DISP_W-1:0]  cfg_wdata_i,
  input  logic                        upd_i,
  input  logic                        clr_i,
  input  logic [des_pkg::DISP_W-1:0]  est_i,
  input  logic [des_pkg::DISP_W-1:0]  true_i,
  output logic [des_pkg::COLOR_W-1:0] color_o,
  output des_pkg::des_stats_t         stats_o
);
  import des_pkg::*;

  logic [DISP_W-1:0]   occ_q;
  logic [DISP_W-1:0]   err;
  logic [2*DISP_W-1:0] sq;
  logic [BIN_W-1:0]    bin;
  logic                counted;
  logic [SSE_W:0]      sse_sum;
  des_stats_t          stats_q, stats_d;

  always_comb begin
    counted = (true_i != '0) && (est_i != occ_q);
    err     = (true_i >= est_i) ? true_i - est_i : est_i - true_i;
    sq      = err * err;
    bin     = (int'(err) > ERROR_CLAMP) ? BIN_W'(ERROR_CLAMP) : BIN_W'(err);
    color_o = counted ? color_of(bin) : '0;
    sse_sum = {1'b0, stats_q.sse} + (SSE_W + 1)'(sq);
  end

  always_comb begin
    stats_d = stats_q;
    if (clr_i) begin
      stats_d = '0;
    end else if (upd_i && counted) begin
      stats_d.count = sat_inc(stats_q.count);
      for (int b = 0; b < NUM_BINS; b++) begin
        if (int'(bin) == b) begin
          stats_d.hist[b] = sat_inc(stats_q.hist[b]);
        end
      end
      stats_d.sse = sse_sum[SSE_W] ? '1 : sse_sum[SSE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q <= '0;
      occ_q   <= OCC_RESET;
    end else begin
      stats_q <= stats_d;
      if (cfg_we_i) begin
        occ_q <= cfg_wdata_i;
      end
    end
  end

  assign stats_o = stats_q;

endmodule

// File: design/des_iter.sv
// ----------------------------------------------------------------------------
// des_iter
// shared shift / compare / subtract unit: restoring divide or integer root
// ----------------------------------------------------------------------------
module des_iter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  des_pkg::des_iter_req_t req_i,
  output des_pkg::des_iter_rsp_t rsp_o
);
  import des_pkg::*;

  logic                   busy_q;
  logic                   done_q;
  logic [STEP_W-1:0]      step_q;
  des_mode_e              mode_q;
  logic [DIV_W-1:0]       acc_q;
  logic [REM_W-1:0]       rem_q;
  logic [DIV_W-1:0]       res_q;
  logic [COUNT_WIDTH-1:0] div_q;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] sub;
  logic [REM_W:0]   diff;
  logic             fits;

  // one digit: shift in one dividend bit or two radicand bits, then trial subtract
  always_comb begin
    if (mode_q == MODE_SQRT) begin
      rem_sh = {rem_q[REM_W-3:0], acc_q[DIV_W-1 -: 2]};
      sub    = REM_W'({res_q[ROOT_W-1:0], 2'b01});
    end else begin
      rem_sh = {rem_q[REM_W-2:0], acc_q[DIV_W-1]};
      sub    = REM_W'(div_q);
    end
    diff = {1'b0, rem_sh} - {1'b0, sub};
    fits = !diff[REM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= (req_i.mode == MODE_SQRT) ? STEP_W'(ROOT_W) : STEP_W'(DIV_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      acc_q  <= req_i.operand;
      div_q  <= req_i.divisor;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (busy_q) begin
      acc_q <= (mode_q == MODE_SQRT) ? {acc_q[DIV_W-3:0], 2'b00} : {acc_q[DIV_W-2:0], 1'b0};
      rem_q <= fits ? diff[REM_W-1:0] : rem_sh;
      res_q <= {res_q[DIV_W-2:0], fits};
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule
